// ===== src/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types, widths and constants for the steering agent step block.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int CFG_W     = 31;              // config register / unsigned input width
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W     = 31;              // component magnitude after range shift
    localparam int VEC_W     = 48;              // work vector component, signed
    localparam int SH_W      = 5;               // range shift count
    localparam int SUM_W     = 64;              // sum of squares
    localparam int LEN_W     = 33;              // vector length
    localparam int DIST_W    = LEN_W + 3;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int DIV_W     = 64;              // dividend / quotient width

    localparam logic [CFG_W-1:0] CFG_ONE  = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] EPS_RAW  =
        (FRAC_BITS > 23) ? (CFG_W'(1) << (FRAC_BITS - 23)) : CFG_W'(1);
    localparam logic [MAG_W-1:0] WORD_MAX = {MAG_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SEEK   = 2'd1,
        CMD_FLEE   = 2'd2,
        CMD_ARRIVE = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGENT_MASS  = 2'd0,
        CFG_FORCE_LIMIT = 2'd1,
        CFG_SPEED_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LD_SEEK,
        OP_LD_FLEE,
        OP_LD_ARR,
        OP_LD_FRC,
        OP_ABS,
        OP_SHIFT,
        OP_SQ,
        OP_ACC,
        OP_SQRT_GO,
        OP_ARR_MUL,
        OP_ARR_DGO,
        OP_ARR_LIM,
        OP_SC_MUL,
        OP_SC_DGO,
        OP_SC_WR,
        OP_FORCE,
        OP_AC_DGO,
        OP_AC_MUL,
        OP_AC_WR,
        OP_LIM_SPEED,
        OP_MOVE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic        latch;
        dp_op_t      op;
        logic [1:0]  idx;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic big;
        logic len_zero;
        logic no_clamp;
        logic frc_zero;
        logic near;
        logic far;
        logic div_done;
        logic sqrt_done;
    } dp_stat_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [WORD_BITS-1:0] target_x;
        logic signed [WORD_BITS-1:0] target_y;
        logic signed [WORD_BITS-1:0] target_z;
        logic signed [WORD_BITS-1:0] target_vel_x;
        logic signed [WORD_BITS-1:0] target_vel_y;
        logic signed [WORD_BITS-1:0] target_vel_z;
        logic [CFG_W-1:0]        slowing_distance;
        logic [CFG_W-1:0]        delta_time;
    } item_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] pos_x;
        logic signed [WORD_BITS-1:0] pos_y;
        logic signed [WORD_BITS-1:0] pos_z;
        logic signed [WORD_BITS-1:0] vel_x;
        logic signed [WORD_BITS-1:0] vel_y;
        logic signed [WORD_BITS-1:0] vel_z;
    } res_t;

    // saturate a wide signed value to a state word
    function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [VEC_W:0] v);
        logic [VEC_W-WORD_BITS+1:0] top;
        top = v[VEC_W:WORD_BITS-1];
        if (top == '0 || top == '1) begin
            return v[WORD_BITS-1:0];
        end
        else if (v[VEC_W]) begin
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else begin
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    endfunction

endpackage

// ===== src/sas_req_if.sv =====
// ----------------------------------------------------------------------------
// sas_req_if
// Request channel: one command item with target and timing fields.
// ----------------------------------------------------------------------------
interface sas_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_vel_x;
    logic signed [31:0] target_vel_y;
    logic signed [31:0] target_vel_z;
    logic [30:0] slowing_distance;
    logic [30:0] delta_time;

    modport source (
        output valid, cmd, target_x, target_y, target_z,
               target_vel_x, target_vel_y, target_vel_z, slowing_distance, delta_time,
        input  ready
    );
    modport sink (
        input  valid, cmd, target_x, target_y, target_z,
               target_vel_x, target_vel_y, target_vel_z, slowing_distance, delta_time,
        output ready
    );
endinterface

// ===== src/sas_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sas_rsp_if
// Response channel: agent position and velocity after each item.
// ----------------------------------------------------------------------------
interface sas_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output ready
    );
endinterface

// ===== src/steering_agent_step.sv =====
// ----------------------------------------------------------------------------
// steering_agent_step
// One steering agent: seek/pursuit, flee/evade, arrival and tick update
// in signed Q16.16, one item at a time.
// ----------------------------------------------------------------------------
// One item in work at a time; a tick with zero force goes straight to the
//   output. Run time is set mostly by the shared bit-serial divider, which
//   works one component at a time, and by the square root unit.
// A finished result waits in an output register; the next item is taken meanwhile.
// Reset (rst_n, async, active low) clears position, velocity and force, sets
//   mass, force limit and speed limit to 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module steering_agent_step (
    input  logic                          clk,
    input  logic                          rst_n,
    sas_req_if.sink                       req,
    sas_rsp_if.source                     rsp,
    input  logic                          cfg_wr_en,
    input  logic [sas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sas_pkg::CFG_W-1:0]     cfg_data
);

    sas_pkg::dp_cmd_t  cmd;
    sas_pkg::dp_stat_t stat;
    sas_pkg::item_t    item;
    sas_pkg::res_t     res;

    // pack the request payload for the datapath's item register
    assign item.cmd              = sas_pkg::cmd_t'(req.cmd);
    assign item.target_x         = req.target_x;
    assign item.target_y         = req.target_y;
    assign item.target_z         = req.target_z;
    assign item.target_vel_x     = req.target_vel_x;
    assign item.target_vel_y     = req.target_vel_y;
    assign item.target_vel_z     = req.target_vel_z;
    assign item.slowing_distance = req.slowing_distance;
    assign item.delta_time       = req.delta_time;

    // sequencer: owns the handshakes and the output valid
    sas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // agent state, config and arithmetic units
    sas_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    assign rsp.pos_x = res.pos_x;
    assign rsp.pos_y = res.pos_y;
    assign rsp.pos_z = res.pos_z;
    assign rsp.vel_x = res.vel_x;
    assign rsp.vel_y = res.vel_y;
    assign rsp.vel_z = res.vel_z;

endmodule

// ===== src/sas_div.sv =====
// ----------------------------------------------------------------------------
// sas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sas_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sas_pkg::DIV_W-1:0]   dividend,
    input  logic [sas_pkg::LEN_W-1:0]   divisor,
    output logic                        done,
    output logic [sas_pkg::DIV_W-1:0]   quotient
);

    logic [sas_pkg::DIV_W-1:0] q_reg;
    logic [sas_pkg::LEN_W-1:0] rem_reg;
    logic [sas_pkg::LEN_W-1:0] dvs_reg;
    logic [6:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [sas_pkg::LEN_W:0]   rem_sh;
    logic                      fits;

    assign rem_sh = {rem_reg, q_reg[sas_pkg::DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(sas_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[sas_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? sas_pkg::LEN_W'(rem_sh - {1'b0, dvs_reg})
                            : rem_sh[sas_pkg::LEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/sas_sqrt.sv =====
// ----------------------------------------------------------------------------
// sas_sqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sas_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sas_pkg::SUM_W-1:0]   radicand,
    output logic                        done,
    output logic [sas_pkg::LEN_W-1:0]   root
);

    logic [sas_pkg::SUM_W-1:0] n_reg;
    logic [sas_pkg::SUM_W-1:0] r_reg;
    logic [sas_pkg::SUM_W-1:0] bit_reg;
    logic [5:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [sas_pkg::SUM_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(sas_pkg::SUM_W / 2);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= sas_pkg::SUM_W'(1) << (sas_pkg::SUM_W - 2);
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[sas_pkg::LEN_W-1:0];

endmodule

// ===== src/sas_datapath.sv =====
// ----------------------------------------------------------------------------
// sas_datapath
// Agent state, config registers, work vector, shared multiplier, divider
// and square root unit, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module sas_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sas_pkg::dp_cmd_t            cmd,
    output sas_pkg::dp_stat_t           stat,
    input  sas_pkg::item_t              item,
    input  logic                        cfg_wr_en,
    input  logic [sas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sas_pkg::CFG_W-1:0]   cfg_data,
    output sas_pkg::res_t               res
);

    localparam int WB = sas_pkg::WORD_BITS;
    localparam int VW = sas_pkg::VEC_W;

    // agent state and config
    logic signed [WB-1:0] pos_reg [3];
    logic signed [WB-1:0] vel_reg [3];
    logic signed [WB-1:0] frc_reg [3];
    logic [sas_pkg::CFG_W-1:0] mass_reg, flim_reg, slim_reg;

    // work registers
    sas_pkg::item_t              item_reg;
    logic signed [VW-1:0]        w_reg   [3];
    logic [VW-1:0]               mag_reg [3];
    logic                        neg_reg [3];
    logic [sas_pkg::SH_W-1:0]    sh_reg;
    logic [sas_pkg::SUM_W-1:0]   sum_reg;
    logic [sas_pkg::PROD_W-1:0]  prod_reg;
    logic [sas_pkg::LEN_W-1:0]   len_reg;
    logic [sas_pkg::CFG_W-1:0]   lim_reg;
    sas_pkg::res_t               res_reg;

    logic signed [WB-1:0]        tgt  [3];
    logic signed [WB-1:0]        tvel [3];
    logic signed [33:0]          d_seek [3];
    logic signed [33:0]          d_arr  [3];
    logic signed [WB-1:0]        vel_new [3];
    logic [VW-1:0]               wabs;
    logic [sas_pkg::DIST_W-1:0]  dist_len;
    logic [sas_pkg::CFG_W-1:0]   slow_eff;
    logic [sas_pkg::CFG_W-1:0]   mass_eff;
    logic [sas_pkg::MAG_W-1:0]   mul_a, mul_b;
    logic [sas_pkg::MAG_W-1:0]   acc_mag;
    logic [sas_pkg::PROD_W-sas_pkg::FRAC_BITS-1:0] step_mag;
    logic signed [VW-1:0]        step_s;
    logic signed [VW-1:0]        quot_s;

    logic                        div_start;
    logic [sas_pkg::DIV_W-1:0]   div_dvd;
    logic [sas_pkg::LEN_W-1:0]   div_dvs;
    logic                        div_done;
    logic [sas_pkg::DIV_W-1:0]   quot;
    logic                        sqrt_done;
    logic [sas_pkg::LEN_W-1:0]   root;

    assign tgt[0]  = item_reg.target_x;
    assign tgt[1]  = item_reg.target_y;
    assign tgt[2]  = item_reg.target_z;
    assign tvel[0] = item_reg.target_vel_x;
    assign tvel[1] = item_reg.target_vel_y;
    assign tvel[2] = item_reg.target_vel_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_seek[i] = 34'(tgt[i]) + 34'(tvel[i]) - 34'(pos_reg[i]);
            d_arr[i]  = 34'(tgt[i]) - 34'(pos_reg[i]);
            vel_new[i] = sas_pkg::sat_word((VW+1)'(w_reg[i]));
        end
    end

    assign wabs     = w_reg[cmd.idx][VW-1] ? $unsigned(-w_reg[cmd.idx])
                                           : $unsigned(w_reg[cmd.idx]);
    assign dist_len = sas_pkg::DIST_W'(len_reg) << sh_reg;
    assign slow_eff = (item_reg.slowing_distance < sas_pkg::EPS_RAW) ? sas_pkg::EPS_RAW
                                                                      : item_reg.slowing_distance;
    assign mass_eff = (mass_reg == '0) ? sas_pkg::CFG_W'(1) : mass_reg;
    assign acc_mag  = (quot > sas_pkg::DIV_W'(sas_pkg::WORD_MAX)) ? sas_pkg::WORD_MAX
                                                                  : quot[sas_pkg::MAG_W-1:0];
    assign step_mag = prod_reg[sas_pkg::PROD_W-1:sas_pkg::FRAC_BITS];
    assign step_s   = $signed(VW'(step_mag));
    assign quot_s   = $signed(VW'(quot[sas_pkg::MAG_W-1:0]));

    // shared multiplier operands
    always_comb
    begin
        mul_a = mag_reg[cmd.idx][sas_pkg::MAG_W-1:0];
        mul_b = mag_reg[cmd.idx][sas_pkg::MAG_W-1:0];
        case (cmd.op)
            sas_pkg::OP_SC_MUL:
            begin
                mul_b = lim_reg;
            end
            sas_pkg::OP_ARR_MUL:
            begin
                mul_a = slim_reg;
                mul_b = dist_len[sas_pkg::MAG_W-1:0];
            end
            sas_pkg::OP_AC_MUL:
            begin
                mul_a = acc_mag;
                mul_b = item_reg.delta_time;
            end
            default:
            begin
            end
        endcase
    end

    // divider operand selection
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = sas_pkg::DIV_W'(prod_reg);
        div_dvs   = len_reg;
        case (cmd.op)
            sas_pkg::OP_SC_DGO:
            begin
                div_start = 1'b1;
            end
            sas_pkg::OP_ARR_DGO:
            begin
                div_start = 1'b1;
                div_dvs   = sas_pkg::LEN_W'(slow_eff);
            end
            sas_pkg::OP_AC_DGO:
            begin
                div_start = 1'b1;
                div_dvd   = sas_pkg::DIV_W'(wabs) << sas_pkg::FRAC_BITS;
                div_dvs   = sas_pkg::LEN_W'(mass_eff);
            end
            default:
            begin
            end
        endcase
    end

    sas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quot)
    );

    sas_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == sas_pkg::OP_SQRT_GO),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // agent state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                frc_reg[i] <= '0;
            end
            mass_reg <= sas_pkg::CFG_ONE;
            flim_reg <= sas_pkg::CFG_ONE;
            slim_reg <= sas_pkg::CFG_ONE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    sas_pkg::CFG_AGENT_MASS:  mass_reg <= cfg_data;
                    sas_pkg::CFG_FORCE_LIMIT: flim_reg <= cfg_data;
                    sas_pkg::CFG_SPEED_LIMIT: slim_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            unique case (cmd.op)
                sas_pkg::OP_FORCE:
                begin
                    for (int i = 0; i < 3; i++)
                        frc_reg[i] <= sas_pkg::sat_word((VW+1)'(w_reg[i]) - (VW+1)'(vel_reg[i]));
                end
                sas_pkg::OP_MOVE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        vel_reg[i] <= vel_new[i];
                        pos_reg[i] <= sas_pkg::sat_word((VW+1)'(pos_reg[i]) + (VW+1)'(vel_new[i]));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= item;
        if (sqrt_done)
            len_reg <= root;
        unique case (cmd.op)
            sas_pkg::OP_LD_SEEK:
            begin
                for (int i = 0; i < 3; i++)
                    w_reg[i] <= VW'(d_seek[i]);
                lim_reg <= slim_reg;
            end
            sas_pkg::OP_LD_FLEE:
            begin
                for (int i = 0; i < 3; i++)
                    w_reg[i] <= VW'(-d_seek[i]);
                lim_reg <= slim_reg;
            end
            sas_pkg::OP_LD_ARR:
            begin
                for (int i = 0; i < 3; i++)
                    w_reg[i] <= VW'(d_arr[i]);
                lim_reg <= slim_reg;
            end
            sas_pkg::OP_LD_FRC:
            begin
                for (int i = 0; i < 3; i++)
                    w_reg[i] <= VW'(frc_reg[i]);
                lim_reg <= flim_reg;
            end
            sas_pkg::OP_LIM_SPEED:
            begin
                lim_reg <= slim_reg;
            end
            sas_pkg::OP_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= w_reg[i][VW-1];
                    mag_reg[i] <= w_reg[i][VW-1] ? $unsigned(-w_reg[i]) : $unsigned(w_reg[i]);
                end
                sh_reg  <= '0;
                sum_reg <= '0;
            end
            sas_pkg::OP_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= mag_reg[i] >> 1;
                sh_reg <= sh_reg + sas_pkg::SH_W'(1);
            end
            sas_pkg::OP_SQ, sas_pkg::OP_SC_MUL, sas_pkg::OP_ARR_MUL, sas_pkg::OP_AC_MUL:
            begin
                prod_reg <= sas_pkg::PROD_W'(mul_a) * sas_pkg::PROD_W'(mul_b);
            end
            sas_pkg::OP_ACC:
            begin
                sum_reg <= sum_reg + sas_pkg::SUM_W'(prod_reg);
            end
            sas_pkg::OP_ARR_LIM:
            begin
                lim_reg <= quot[sas_pkg::CFG_W-1:0];
            end
            sas_pkg::OP_SC_WR:
            begin
                if (len_reg == '0)
                    w_reg[cmd.idx] <= '0;
                else
                    w_reg[cmd.idx] <= neg_reg[cmd.idx] ? -quot_s : quot_s;
            end
            sas_pkg::OP_AC_WR:
            begin
                w_reg[cmd.idx] <= VW'(vel_reg[cmd.idx])
                                + (w_reg[cmd.idx][VW-1] ? -step_s : step_s);
            end
            sas_pkg::OP_OUT:
            begin
                res_reg.pos_x <= pos_reg[0];
                res_reg.pos_y <= pos_reg[1];
                res_reg.pos_z <= pos_reg[2];
                res_reg.vel_x <= vel_reg[0];
                res_reg.vel_y <= vel_reg[1];
                res_reg.vel_z <= vel_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.cmd       = item_reg.cmd;
        stat.big       = (mag_reg[0][VW-1:sas_pkg::MAG_W] != '0)
                      || (mag_reg[1][VW-1:sas_pkg::MAG_W] != '0)
                      || (mag_reg[2][VW-1:sas_pkg::MAG_W] != '0);
        stat.len_zero  = (len_reg == '0);
        stat.no_clamp  = (sh_reg == '0) && (len_reg <= sas_pkg::LEN_W'(lim_reg));
        stat.frc_zero  = (frc_reg[0] == '0) && (frc_reg[1] == '0) && (frc_reg[2] == '0);
        stat.near      = dist_len < sas_pkg::DIST_W'(sas_pkg::EPS_RAW);
        stat.far       = dist_len >= sas_pkg::DIST_W'(slow_eff);
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
    end

    assign res = res_reg;

endmodule

// ===== src/sas_ctrl.sv =====
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencer: steps the datapath through seek, flee, arrival and tick.
// ----------------------------------------------------------------------------
module sas_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  sas_pkg::dp_stat_t   stat,
    output sas_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ABS, S_SHIFT, S_SQ, S_ACC, S_SQRT_GO, S_SQRT_WAIT,
        S_DECIDE, S_ARR_MUL, S_ARR_DGO, S_ARR_DWAIT, S_ARR_LIM,
        S_SC_MUL, S_SC_DGO, S_SC_DWAIT, S_SC_WR, S_FORCE,
        S_AC_DGO, S_AC_DWAIT, S_AC_MUL, S_AC_WR, S_VLIM, S_MOVE, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_SEEK, PH_ARR, PH_FCLAMP, PH_VCLAMP
    } phase_t;

    state_t     state_reg;
    phase_t     phase_reg;
    logic [1:0] idx_reg;
    logic       rsp_valid_reg;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.latch = (state_reg == S_IDLE) && req_valid;
        cmd.idx   = idx_reg;
        cmd.op    = sas_pkg::OP_NOP;
        unique case (state_reg)
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    sas_pkg::CMD_TICK:  cmd.op = stat.frc_zero ? sas_pkg::OP_NOP
                                                               : sas_pkg::OP_LD_FRC;
                    sas_pkg::CMD_SEEK:  cmd.op = sas_pkg::OP_LD_SEEK;
                    sas_pkg::CMD_FLEE:  cmd.op = sas_pkg::OP_LD_FLEE;
                    default:            cmd.op = sas_pkg::OP_LD_ARR;
                endcase
            end
            S_ABS:       cmd.op = sas_pkg::OP_ABS;
            S_SHIFT:     cmd.op = stat.big ? sas_pkg::OP_SHIFT : sas_pkg::OP_NOP;
            S_SQ:        cmd.op = sas_pkg::OP_SQ;
            S_ACC:       cmd.op = sas_pkg::OP_ACC;
            S_SQRT_GO:   cmd.op = sas_pkg::OP_SQRT_GO;
            S_ARR_MUL:   cmd.op = sas_pkg::OP_ARR_MUL;
            S_ARR_DGO:   cmd.op = sas_pkg::OP_ARR_DGO;
            S_ARR_LIM:   cmd.op = sas_pkg::OP_ARR_LIM;
            S_SC_MUL:    cmd.op = stat.len_zero ? sas_pkg::OP_NOP : sas_pkg::OP_SC_MUL;
            S_SC_DGO:    cmd.op = sas_pkg::OP_SC_DGO;
            S_SC_WR:     cmd.op = sas_pkg::OP_SC_WR;
            S_FORCE:     cmd.op = sas_pkg::OP_FORCE;
            S_AC_DGO:    cmd.op = sas_pkg::OP_AC_DGO;
            S_AC_MUL:    cmd.op = sas_pkg::OP_AC_MUL;
            S_AC_WR:     cmd.op = sas_pkg::OP_AC_WR;
            S_VLIM:      cmd.op = sas_pkg::OP_LIM_SPEED;
            S_MOVE:      cmd.op = sas_pkg::OP_MOVE;
            S_OUT:       cmd.op = out_free ? sas_pkg::OP_OUT : sas_pkg::OP_NOP;
            default:     cmd.op = sas_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SEEK;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_ready && !(state_reg == S_OUT && out_free))
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                        state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    unique case (stat.cmd)
                        sas_pkg::CMD_TICK:
                        begin
                            phase_reg <= PH_FCLAMP;
                            state_reg <= stat.frc_zero ? S_OUT : S_ABS;
                        end
                        sas_pkg::CMD_SEEK, sas_pkg::CMD_FLEE:
                        begin
                            phase_reg <= PH_SEEK;
                            state_reg <= S_ABS;
                        end
                        default:
                        begin
                            phase_reg <= PH_ARR;
                            state_reg <= S_ABS;
                        end
                    endcase
                end
                S_ABS:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (!stat.big)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (idx_reg == 2'd2)
                        state_reg <= S_SQRT_GO;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQRT_GO:
                begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (stat.sqrt_done)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    idx_reg <= '0;
                    unique case (phase_reg)
                        PH_SEEK:
                            state_reg <= S_SC_MUL;
                        PH_ARR:
                        begin
                            if (stat.near)
                                state_reg <= S_OUT;
                            else if (stat.far)
                                state_reg <= S_SC_MUL;
                            else
                                state_reg <= S_ARR_MUL;
                        end
                        PH_FCLAMP:
                            state_reg <= (stat.len_zero || stat.no_clamp) ? S_AC_DGO : S_SC_MUL;
                        default:
                            state_reg <= (stat.len_zero || stat.no_clamp) ? S_MOVE : S_SC_MUL;
                    endcase
                end
                S_ARR_MUL:
                begin
                    state_reg <= S_ARR_DGO;
                end
                S_ARR_DGO:
                begin
                    state_reg <= S_ARR_DWAIT;
                end
                S_ARR_DWAIT:
                begin
                    if (stat.div_done)
                        state_reg <= S_ARR_LIM;
                end
                S_ARR_LIM:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_SC_MUL;
                end
                S_SC_MUL:
                begin
                    state_reg <= stat.len_zero ? S_SC_WR : S_SC_DGO;
                end
                S_SC_DGO:
                begin
                    state_reg <= S_SC_DWAIT;
                end
                S_SC_DWAIT:
                begin
                    if (stat.div_done)
                        state_reg <= S_SC_WR;
                end
                S_SC_WR:
                begin
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg <= '0;
                        unique case (phase_reg)
                            PH_FCLAMP: state_reg <= S_AC_DGO;
                            PH_VCLAMP: state_reg <= S_MOVE;
                            default:   state_reg <= S_FORCE;
                        endcase
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SC_MUL;
                    end
                end
                S_FORCE:
                begin
                    state_reg <= S_OUT;
                end
                S_AC_DGO:
                begin
                    state_reg <= S_AC_DWAIT;
                end
                S_AC_DWAIT:
                begin
                    if (stat.div_done)
                        state_reg <= S_AC_MUL;
                end
                S_AC_MUL:
                begin
                    state_reg <= S_AC_WR;
                end
                S_AC_WR:
                begin
                    if (idx_reg == 2'd2)
                        state_reg <= S_VLIM;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_AC_DGO;
                    end
                end
                S_VLIM:
                begin
                    phase_reg <= PH_VCLAMP;
                    state_reg <= S_ABS;
                end
                S_MOVE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
